FILE: rtl/fxa_pkg.sv
// package: command codes, status codes and the io word width for the q24.8 alu
package fxa_pkg;

  typedef enum logic [3:0] {
    CMD_ADD     = 4'd0,
    CMD_SUB     = 4'd1,
    CMD_MUL     = 4'd2,
    CMD_DIV     = 4'd3,
    CMD_GT      = 4'd4,
    CMD_LT      = 4'd5,
    CMD_EQ      = 4'd6,
    CMD_NE      = 4'd7,
    CMD_LE      = 4'd8,
    CMD_GE      = 4'd9,
    CMD_MIN     = 4'd10,
    CMD_MAX     = 4'd11,
    CMD_INC     = 4'd12,
    CMD_DEC     = 4'd13,
    CMD_TO_INT  = 4'd14,
    CMD_FROM_INT = 4'd15
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OVF   = 2'd1,
    ST_DIV0  = 2'd2
  } status_t;

  localparam int IO_BITS = 32;

endpackage

FILE: rtl/fxa_if.sv
// interfaces: valid/ready channels for operation words and result words
interface fxa_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  command;
  logic signed [31:0] operand_a;
  logic signed [31:0] operand_b;
  modport source (output valid, command, operand_a, operand_b, input ready);
  modport sink   (input valid, command, operand_a, operand_b, output ready);
endinterface

interface fxa_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] result_value;
  logic        compare_true;
  logic [1:0]  status;
  modport source (output valid, result_value, compare_true, status, input ready);
  modport sink   (input valid, result_value, compare_true, status, output ready);
endinterface

FILE: rtl/fxa_cell.sv
// one pipeline cell: a single restoring divide step plus pass-through of the word
module fxa_cell #(
  parameter int NB = 48,
  parameter int QB = 48,
  parameter int IW = 104,
  parameter int STEP = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          vld_i,
  input  logic [NB-1:0] rem_i,
  input  logic [QB-1:0] quo_i,
  input  logic [NB-1:0] dvs_i,
  input  logic [QB-1:0] num_i,
  input  logic [3:0]    cmd_i,
  input  logic [IW-1:0] pay_i,
  output logic          vld_o,
  output logic [NB-1:0] rem_o,
  output logic [QB-1:0] quo_o,
  output logic [NB-1:0] dvs_o,
  output logic [QB-1:0] num_o,
  output logic [3:0]    cmd_o,
  output logic [IW-1:0] pay_o
);
  logic [NB:0] sh;
  logic [NB:0] df;
  logic        vld_r;
  logic [NB-1:0] rem_r;
  logic [QB-1:0] quo_r;
  logic [NB-1:0] dvs_r;
  logic [QB-1:0] num_r;
  logic [3:0]    cmd_r;
  logic [IW-1:0] pay_r;

  always_comb begin
    sh = {rem_i, num_i[QB-1-STEP]};
    df = sh - {1'b0, dvs_i};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!df[NB]) begin
        rem_r <= df[NB-1:0];
        quo_r <= {quo_i[QB-2:0], 1'b1};
      end else begin
        rem_r <= sh[NB-1:0];
        quo_r <= {quo_i[QB-2:0], 1'b0};
      end
      dvs_r <= dvs_i;
      num_r <= num_i;
      cmd_r <= cmd_i;
      pay_r <= pay_i;
    end
  end

  assign vld_o = vld_r;
  assign rem_o = rem_r;
  assign quo_o = quo_r;
  assign dvs_o = dvs_r;
  assign num_o = num_r;
  assign cmd_o = cmd_r;
  assign pay_o = pay_r;
endmodule

FILE: rtl/fixed_point_q24_8_alu.sv
// top level: q24.8 fixed point alu built as a row of divide-step cells
// Accepts one operation word per cycle while the output is not stalled, and returns one result
// word per operation, in order. One entry stage forms operands and the exact multiply product,
// one cell per quotient bit runs the restoring divide, and a final stage rounds, saturates and
// selects; all commands travel the same row so order is kept. The whole row stalls only when
// the output register holds an untaken word.
module fixed_point_q24_8_alu #(
  parameter int FRAC_BITS = 8,
  parameter int WORD_BITS = 32
) (
  input logic  clk,
  input logic  rst_n,
  fxa_in_if.sink    in_ch,
  fxa_out_if.source out_ch
);
  import fxa_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int QB = W + FRAC_BITS;
  localparam int NB = W;
  localparam int IW = 2*NB + 8;

  logic [W-1:0] maxp, minn;
  assign maxp = {1'b0, {(W-1){1'b1}}};
  assign minn = {1'b1, {(W-1){1'b0}}};

  logic en;
  logic out_vld_r;
  assign en = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  // entry: extend operands, take magnitudes and form the product
  logic [W-1:0] a, b, ma, mb;
  always_comb begin
    a  = W'({{(64){in_ch.operand_a[31]}}, in_ch.operand_a});
    b  = W'({{(64){in_ch.operand_b[31]}}, in_ch.operand_b});
    ma = a[W-1] ? W'(-a) : a;
    mb = b[W-1] ? W'(-b) : b;
  end

  // payload: a (W), b (W), flags (8)
  logic          v0_r;
  logic [3:0]    c0_r;
  logic [QB-1:0] n0_r;
  logic [NB-1:0] d0_r;
  logic [IW-1:0] p0_r;
  logic [2*W-1:0] prod0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else if (en) v0_r <= in_ch.valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      c0_r <= in_ch.command;
      n0_r <= QB'({ma, {FRAC_BITS{1'b0}}});
      d0_r <= mb;
      p0_r <= {a, b, 8'd0};
    end
  end

  // product pipeline alongside the row (one multiplier, registered, then shift line)
  logic [2*W-1:0] prod_nxt;
  assign prod_nxt = ma * mb;
  always_ff @(posedge clk) if (en) prod0_r <= prod_nxt;

  logic [2*W-1:0] prod_line [QB];
  always_ff @(posedge clk) begin
    if (en) begin
      prod_line[0] <= prod0_r;
      for (int k = 1; k < QB; k++) prod_line[k] <= prod_line[k-1];
    end
  end

  logic          vv [QB+1];
  logic [NB-1:0] rr [QB+1];
  logic [QB-1:0] qq [QB+1];
  logic [NB-1:0] dd [QB+1];
  logic [QB-1:0] nn [QB+1];
  logic [3:0]    cc [QB+1];
  logic [IW-1:0] pp [QB+1];
  assign vv[0] = v0_r;
  assign rr[0] = '0;
  assign qq[0] = '0;
  assign dd[0] = d0_r;
  assign nn[0] = n0_r;
  assign cc[0] = c0_r;
  assign pp[0] = p0_r;

  for (genvar g = 0; g < QB; g++) begin : g_row
    fxa_cell #(.NB(NB), .QB(QB), .IW(IW), .STEP(g)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .vld_i(vv[g]), .rem_i(rr[g]), .quo_i(qq[g]), .dvs_i(dd[g]), .num_i(nn[g]),
      .cmd_i(cc[g]), .pay_i(pp[g]),
      .vld_o(vv[g+1]), .rem_o(rr[g+1]), .quo_o(qq[g+1]), .dvs_o(dd[g+1]),
      .num_o(nn[g+1]), .cmd_o(cc[g+1]), .pay_o(pp[g+1])
    );
  end

  // final stage
  logic [W-1:0] fa, fb, res, sat_v;
  logic [3:0]   fc;
  logic         neg, ct, ltab, ltba;
  logic [1:0]   st;
  logic [2*W:0] prnd;
  logic [2*W:0] pmag;
  logic [QB:0]  qmag;
  logic [NB:0]  rem2;
  logic [W-1:0] fmag;
  logic         fneg;

  always_comb begin
    fa   = pp[QB][IW-1 -: W];
    fb   = pp[QB][IW-1-W -: W];
    fc   = cc[QB];
    neg  = fa[W-1] ^ fb[W-1];
    ltab = $signed(fa) < $signed(fb);
    ltba = $signed(fb) < $signed(fa);
    res  = '0;
    ct   = 1'b0;
    st   = ST_OK;
    sat_v = '0;
    prnd = '0;
    pmag = '0;
    qmag = '0;
    rem2 = '0;
    fmag = fa[W-1] ? W'(-fa) : fa;
    fneg = fa[W-1];
    case (cmd_t'(fc))
      CMD_ADD: begin
        res = fa + fb;
        if (fa[W-1] == fb[W-1] && res[W-1] != fa[W-1]) begin
          st = ST_OVF; res = fa[W-1] ? minn : maxp;
        end
      end
      CMD_SUB: begin
        res = fa - fb;
        if (fa[W-1] != fb[W-1] && res[W-1] != fa[W-1]) begin
          st = ST_OVF; res = fa[W-1] ? minn : maxp;
        end
      end
      CMD_MUL: begin
        if (FRAC_BITS > 0)
          prnd = ({1'b0, prod_line[QB-1]} + ((2*W+1)'(1) << (FRAC_BITS-1))) >> FRAC_BITS;
        else
          prnd = {1'b0, prod_line[QB-1]};
        pmag = prnd;
        if (!neg) begin
          if (pmag > (2*W+1)'(maxp)) begin st = ST_OVF; res = maxp; end
          else res = pmag[W-1:0];
        end else begin
          if (pmag > (2*W+1)'(minn)) begin st = ST_OVF; res = minn; end
          else res = W'(-pmag[W-1:0]);
        end
      end
      CMD_DIV: begin
        if (fb == '0) begin
          st = ST_DIV0; res = fa[W-1] ? minn : maxp;
        end else begin
          rem2 = {1'b0, rr[QB]};
          qmag = {1'b0, qq[QB]};
          if (rem2 >= ({1'b0, dd[QB]} - rem2)) qmag = qmag + 1'b1;
          if (!neg) begin
            if (qmag > (QB+1)'(maxp)) begin st = ST_OVF; res = maxp; end
            else res = qmag[W-1:0];
          end else begin
            if (qmag > (QB+1)'(minn)) begin st = ST_OVF; res = minn; end
            else res = W'(-qmag[W-1:0]);
          end
        end
      end
      CMD_GT:  ct = ltba;
      CMD_LT:  ct = ltab;
      CMD_EQ:  ct = fa == fb;
      CMD_NE:  ct = fa != fb;
      CMD_LE:  ct = !ltba;
      CMD_GE:  ct = !ltab;
      CMD_MIN: res = ltba ? fb : fa;
      CMD_MAX: res = ltab ? fb : fa;
      CMD_INC: begin
        if (fa == maxp) begin st = ST_OVF; res = maxp; end
        else res = fa + 1'b1;
      end
      CMD_DEC: begin
        if (fa == minn) begin st = ST_OVF; res = minn; end
        else res = fa - 1'b1;
      end
      CMD_TO_INT: res = W'($signed(fa) >>> FRAC_BITS);
      CMD_FROM_INT: begin
        sat_v = fneg ? minn : maxp;
        if (fmag > (sat_v >> FRAC_BITS)) begin st = ST_OVF; res = sat_v; end
        else res = fneg ? W'(-(fmag << FRAC_BITS)) : W'(fmag << FRAC_BITS);
      end
      default: res = '0;
    endcase
  end

  logic [IO_BITS-1:0] res_r;
  logic        ct_r;
  logic [1:0]  st_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else if (en) out_vld_r <= vv[QB];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= IO_BITS'({{(64){res[W-1]}}, res});
      ct_r  <= ct;
      st_r  <= st;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.result_value = res_r;
  assign out_ch.compare_true = ct_r;
  assign out_ch.status       = st_r;
endmodule

FILE: rtl/fxa_checker.sv
// checker: port-level properties of the alu, bound to the top level
module fxa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_result_value,
  input logic        out_compare_true,
  input logic [1:0]  out_status
);
  import fxa_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_value))
    else $error("result word changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3)
    else $error("illegal status code");

  a_cmp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_compare_true |-> out_result_value == 0 && out_status == ST_OK)
    else $error("compare word carries value");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");
endmodule

bind fixed_point_q24_8_alu fxa_checker u_fxa_checker (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ch.ready), .out_valid(out_ch.valid),
  .out_ready(out_ch.ready), .out_result_value(out_ch.result_value),
  .out_compare_true(out_ch.compare_true), .out_status(out_ch.status)
);
